// ===== sv/cpsc_pkg.sv =====
// Shared types, constants and codes of the convex polygon segment clipper.
package cpsc_pkg;

    localparam int COORD_W = 12;
    localparam int DW      = COORD_W + 1;
    localparam int MW      = 2 * DW;
    localparam int PW      = MW + 1;
    localparam int RW      = PW + 1;
    localparam int TW      = 17;
    localparam int Q_FRAC  = 16;
    localparam int LW      = DW + TW + 1;
    localparam int DIV_STEPS = TW;

    localparam logic [TW-1:0] Q_ONE = TW'(1) << Q_FRAC;
    localparam logic REQ_LOAD = 1'b0;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic               last_vertex;
    } in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [COORD_W-1:0] out_x0;
        logic [COORD_W-1:0] out_y0;
        logic [COORD_W-1:0] out_x1;
        logic [COORD_W-1:0] out_y1;
    } out_t;

    typedef enum logic [2:0] {
        STAT_STORED    = 3'd0,
        STAT_CONVEX    = 3'd1,
        STAT_NONCONVEX = 3'd2,
        STAT_VISIBLE   = 3'd3,
        STAT_REJECTED  = 3'd4,
        STAT_DISABLED  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CVX_SHIFT,
        OP_CVX_STEP,
        OP_CL_INIT,
        OP_CL_A,
        OP_CL_EDGE,
        OP_CL_M1,
        OP_CL_M2,
        OP_CL_M3,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_T_UPD,
        OP_LERP
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_CVX_RD,
        S_CVX_DAT,
        S_CVX_ACC,
        S_CL_RD0,
        S_CL_A,
        S_CL_RD,
        S_CL_B,
        S_CL_M1,
        S_CL_M2,
        S_CL_M3,
        S_CL_EV,
        S_DIV,
        S_CL_UPD,
        S_CL_NEXT,
        S_CL_FIN,
        S_LERP,
        S_WAIT
    } state_t;

    typedef struct packed {
        dp_op_t  op;
        logic    ram_we;
        logic    out_load;
        status_t status;
        logic [2:0] lidx;
    } cmd_t;

    typedef struct packed {
        logic cr_pos;
        logic cr_neg;
        logic ev_skip;
        logic ev_reject;
        logic ev_div;
        logic te_gt_tl;
    } stat_t;

endpackage

// ===== sv/cpsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cpsc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/cpsc_datapath.sv =====
// Datapath: vertex store, cross products, edge tests, serial divider and endpoint interpolation.
module cpsc_datapath #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                            aclk,
    input  cpsc_pkg::in_t                   s_data,
    input  cpsc_pkg::cmd_t                  cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0] raddr,
    input  logic [$clog2(MAX_VERTICES)-1:0] waddr,
    output cpsc_pkg::stat_t                 stat,
    output cpsc_pkg::out_t                  m_data
);
    import cpsc_pkg::*;

    in_t                       in_reg;
    logic signed [DW-1:0]      dx_reg, dy_reg;
    logic [COORD_W-1:0]        ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [DW-1:0]      nx_reg, ny_reg, ux_reg, uy_reg;
    logic signed [MW-1:0]      m1_reg, m2_reg;
    logic signed [PW-1:0]      dp_reg, num_reg;
    logic [RW-1:0]             rem_reg, den_reg;
    logic [TW-1:0]             q_reg, te_reg, tl_reg;
    logic                      enter_reg;
    logic signed [LW-1:0]      prod_reg;
    logic [COORD_W-1:0]        res_reg [4];
    out_t                      out_reg;

    logic [2*COORD_W-1:0]      rdata;
    logic [COORD_W-1:0]        rx, ry;
    logic signed [DW-1:0]      ex_w, ey_w, fx_w, fy_w;
    logic signed [DW-1:0]      enx_w, eny_w, eux_w, euy_w;
    logic [COORD_W:0]          sumx_w, sumy_w;
    logic signed [PW-1:0]      cross_w;
    logic signed [PW:0]        nn_w, dd_w;
    logic                      dp_neg;
    logic                      ge_w;
    logic [RW-1:0]             diff_w;
    logic signed [DW-1:0]      ld_w;
    logic [TW-1:0]             lt_w;
    logic [2:0]                wi_w;
    logic [COORD_W-1:0]        lbase_w;
    logic [LW-1:0]             pabs_w, psh_w, pstep_w;

    cpsc_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_vram (
        .aclk  (aclk),
        .we    (cmd.ram_we),
        .waddr (waddr),
        .wdata ({in_reg.x0, in_reg.y0}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rx = rdata[2*COORD_W-1:COORD_W];
    assign ry = rdata[COORD_W-1:0];

    always_comb begin
        ex_w   = $signed({1'b0, bx_reg}) - $signed({1'b0, ax_reg});
        ey_w   = $signed({1'b0, by_reg}) - $signed({1'b0, ay_reg});
        fx_w   = $signed({1'b0, rx}) - $signed({1'b0, bx_reg});
        fy_w   = $signed({1'b0, ry}) - $signed({1'b0, by_reg});
        enx_w  = $signed({1'b0, ry}) - $signed({1'b0, ay_reg});
        eny_w  = $signed({1'b0, ax_reg}) - $signed({1'b0, rx});
        sumx_w = {1'b0, ax_reg} + {1'b0, rx};
        sumy_w = {1'b0, ay_reg} + {1'b0, ry};
        eux_w  = $signed({1'b0, in_reg.x0}) - $signed({1'b0, sumx_w[COORD_W:1]});
        euy_w  = $signed({1'b0, in_reg.y0}) - $signed({1'b0, sumy_w[COORD_W:1]});
        cross_w = PW'(m1_reg) - PW'(m2_reg);

        dp_neg = dp_reg[PW-1];
        nn_w   = dp_neg ? -(PW+1)'(num_reg) : (PW+1)'(num_reg);
        dd_w   = dp_neg ? -(PW+1)'(dp_reg) : (PW+1)'(dp_reg);

        stat.cr_pos   = !cross_w[PW-1] && (cross_w != '0);
        stat.cr_neg   = cross_w[PW-1];
        stat.ev_skip  = (dp_reg == '0);
        if (dp_neg) begin
            stat.ev_reject = nn_w > dd_w;
            stat.ev_div    = (nn_w <= dd_w) && !nn_w[PW] && (nn_w != '0);
        end else begin
            stat.ev_reject = nn_w[PW];
            stat.ev_div    = !nn_w[PW] && (nn_w < dd_w);
        end
        stat.te_gt_tl = te_reg > tl_reg;

        ge_w   = rem_reg >= den_reg;
        diff_w = rem_reg - den_reg;

        ld_w    = cmd.lidx[0] ? dy_reg : dx_reg;
        lt_w    = cmd.lidx[1] ? tl_reg : te_reg;
        wi_w    = cmd.lidx - 3'd1;
        lbase_w = wi_w[0] ? in_reg.y0 : in_reg.x0;
        pabs_w  = prod_reg[LW-1] ? LW'(-prod_reg) : LW'(prod_reg);
        psh_w   = pabs_w >> Q_FRAC;
        pstep_w = prod_reg[LW-1] ? -psh_w : psh_w;
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_CAPTURE: begin
                in_reg <= s_data;
                dx_reg <= $signed({1'b0, s_data.x1}) - $signed({1'b0, s_data.x0});
                dy_reg <= $signed({1'b0, s_data.y1}) - $signed({1'b0, s_data.y0});
            end
            OP_CVX_SHIFT: begin
                ax_reg <= bx_reg;
                ay_reg <= by_reg;
                bx_reg <= rx;
                by_reg <= ry;
            end
            OP_CVX_STEP: begin
                m1_reg <= ex_w * fy_w;
                m2_reg <= ey_w * fx_w;
                ax_reg <= bx_reg;
                ay_reg <= by_reg;
                bx_reg <= rx;
                by_reg <= ry;
            end
            OP_CL_INIT: begin
                te_reg <= '0;
                tl_reg <= Q_ONE;
            end
            OP_CL_A: begin
                ax_reg <= rx;
                ay_reg <= ry;
            end
            OP_CL_EDGE: begin
                nx_reg <= enx_w;
                ny_reg <= eny_w;
                ux_reg <= eux_w;
                uy_reg <= euy_w;
                ax_reg <= rx;
                ay_reg <= ry;
            end
            OP_CL_M1: begin
                m1_reg <= nx_reg * dx_reg;
                m2_reg <= ny_reg * dy_reg;
            end
            OP_CL_M2: begin
                dp_reg <= PW'(m1_reg) + PW'(m2_reg);
                m1_reg <= nx_reg * ux_reg;
                m2_reg <= ny_reg * uy_reg;
            end
            OP_CL_M3: begin
                num_reg <= -(PW'(m1_reg) + PW'(m2_reg));
            end
            OP_DIV_INIT: begin
                rem_reg   <= RW'($unsigned(nn_w));
                den_reg   <= RW'($unsigned(dd_w));
                q_reg     <= '0;
                enter_reg <= dp_neg;
            end
            OP_DIV_STEP: begin
                q_reg   <= {q_reg[TW-2:0], ge_w};
                rem_reg <= (ge_w ? diff_w : rem_reg) << 1;
            end
            OP_T_UPD: begin
                if (enter_reg) begin
                    if (q_reg > te_reg) begin
                        te_reg <= q_reg;
                    end
                end else if (q_reg < tl_reg) begin
                    tl_reg <= q_reg;
                end
            end
            OP_LERP: begin
                if (cmd.lidx < 3'd4) begin
                    prod_reg <= ld_w * $signed({1'b0, lt_w});
                end
                if (cmd.lidx != 3'd0) begin
                    res_reg[wi_w[1:0]] <= lbase_w + pstep_w[COORD_W-1:0];
                end
            end
            default: begin
            end
        endcase

        if (cmd.out_load) begin
            out_reg.status <= cmd.status;
            if (cmd.status == STAT_VISIBLE) begin
                out_reg.out_x0 <= res_reg[0];
                out_reg.out_y0 <= res_reg[1];
                out_reg.out_x1 <= res_reg[2];
                out_reg.out_y1 <= res_reg[3];
            end else begin
                out_reg.out_x0 <= '0;
                out_reg.out_y0 <= '0;
                out_reg.out_x1 <= '0;
                out_reg.out_y1 <= '0;
            end
        end
    end

    assign m_data = out_reg;

endmodule

// ===== sv/cpsc_ctrl.sv =====
// Controller state machine: polygon bookkeeping, sequencing and handshakes.
module cpsc_ctrl #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            req_type,
    input  logic                            last_vertex,
    output logic                            m_valid,
    input  logic                            m_ready,
    input  cpsc_pkg::stat_t                 stat,
    output cpsc_pkg::cmd_t                  cmd,
    output logic [$clog2(MAX_VERTICES)-1:0] raddr,
    output logic [$clog2(MAX_VERTICES)-1:0] waddr
);
    import cpsc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int KW = $clog2(MAX_VERTICES + 3);

    state_t         state_reg, state_next;
    logic [NW-1:0]  count_reg, count_next;
    logic           closed_reg, closed_next;
    logic           convex_reg, convex_next;
    logic           pos_reg, pos_next;
    logic           neg_reg, neg_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [NW-1:0]  j_reg, j_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic           last_reg, last_next;
    status_t        status_reg, status_next;
    logic           m_valid_reg, m_valid_next;

    logic [NW-1:0]  cnt_eff;
    logic [AW-1:0]  addr_wrap;
    logic           pos_w, neg_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            closed_reg  <= 1'b0;
            convex_reg  <= 1'b0;
            pos_reg     <= 1'b0;
            neg_reg     <= 1'b0;
            addr_reg    <= '0;
            k_reg       <= '0;
            j_reg       <= '0;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
            status_reg  <= STAT_STORED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            closed_reg  <= closed_next;
            convex_reg  <= convex_next;
            pos_reg     <= pos_next;
            neg_reg     <= neg_next;
            addr_reg    <= addr_next;
            k_reg       <= k_next;
            j_reg       <= j_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        closed_next  = closed_reg;
        convex_next  = convex_reg;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        addr_next    = addr_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.status   = status_reg;
        s_ready      = 1'b0;
        raddr        = addr_reg;
        cnt_eff      = closed_reg ? '0 : count_reg;
        waddr        = cnt_eff[AW-1:0];
        addr_wrap    = (addr_reg == AW'(count_reg - NW'(1))) ? '0 : addr_reg + AW'(1);
        pos_w        = pos_reg || stat.cr_pos;
        neg_w        = neg_reg || stat.cr_neg;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op    = OP_CAPTURE;
                    last_next = last_vertex;
                    if (req_type == REQ_LOAD) begin
                        state_next = S_LOAD;
                    end else if (closed_reg && convex_reg) begin
                        state_next = S_CL_RD0;
                    end else begin
                        status_next = STAT_DISABLED;
                        state_next  = S_WAIT;
                    end
                end
            end
            S_LOAD: begin
                closed_next = 1'b0;
                if (closed_reg) begin
                    convex_next = 1'b0;
                end
                count_next = cnt_eff;
                if (cnt_eff < NW'(MAX_VERTICES)) begin
                    cmd.ram_we = 1'b1;
                    count_next = cnt_eff + NW'(1);
                end
                if (last_reg) begin
                    closed_next = 1'b1;
                    if (count_next < NW'(3)) begin
                        convex_next = 1'b0;
                        status_next = STAT_NONCONVEX;
                        state_next  = S_WAIT;
                    end else begin
                        addr_next  = '0;
                        k_next     = '0;
                        pos_next   = 1'b0;
                        neg_next   = 1'b0;
                        state_next = S_CVX_RD;
                    end
                end else begin
                    status_next = STAT_STORED;
                    state_next  = S_WAIT;
                end
            end
            S_CVX_RD: begin
                state_next = S_CVX_DAT;
            end
            S_CVX_DAT: begin
                addr_next = addr_wrap;
                k_next    = k_reg + KW'(1);
                if (k_reg < KW'(2)) begin
                    cmd.op     = OP_CVX_SHIFT;
                    state_next = S_CVX_RD;
                end else begin
                    cmd.op     = OP_CVX_STEP;
                    state_next = S_CVX_ACC;
                end
            end
            S_CVX_ACC: begin
                pos_next = pos_w;
                neg_next = neg_w;
                if (k_reg == KW'(count_reg) + KW'(2)) begin
                    convex_next = !(pos_w && neg_w);
                    status_next = (pos_w && neg_w) ? STAT_NONCONVEX : STAT_CONVEX;
                    state_next  = S_WAIT;
                end else begin
                    state_next = S_CVX_RD;
                end
            end
            S_CL_RD0: begin
                raddr      = '0;
                cmd.op     = OP_CL_INIT;
                addr_next  = AW'(1);
                state_next = S_CL_A;
            end
            S_CL_A: begin
                cmd.op     = OP_CL_A;
                j_next     = '0;
                state_next = S_CL_RD;
            end
            S_CL_RD: begin
                state_next = S_CL_B;
            end
            S_CL_B: begin
                cmd.op     = OP_CL_EDGE;
                addr_next  = addr_wrap;
                state_next = S_CL_M1;
            end
            S_CL_M1: begin
                cmd.op     = OP_CL_M1;
                state_next = S_CL_M2;
            end
            S_CL_M2: begin
                cmd.op     = OP_CL_M2;
                state_next = S_CL_M3;
            end
            S_CL_M3: begin
                cmd.op     = OP_CL_M3;
                state_next = S_CL_EV;
            end
            S_CL_EV: begin
                priority if (stat.ev_skip) begin
                    state_next = S_CL_NEXT;
                end else if (stat.ev_reject) begin
                    status_next = STAT_REJECTED;
                    state_next  = S_WAIT;
                end else if (stat.ev_div) begin
                    cmd.op     = OP_DIV_INIT;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end else begin
                    state_next = S_CL_NEXT;
                end
            end
            S_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = S_CL_UPD;
                end
            end
            S_CL_UPD: begin
                cmd.op     = OP_T_UPD;
                state_next = S_CL_NEXT;
            end
            S_CL_NEXT: begin
                j_next = j_reg + NW'(1);
                if (j_next == count_reg) begin
                    state_next = S_CL_FIN;
                end else begin
                    state_next = S_CL_RD;
                end
            end
            S_CL_FIN: begin
                if (stat.te_gt_tl) begin
                    status_next = STAT_REJECTED;
                    state_next  = S_WAIT;
                end else begin
                    cnt_next   = '0;
                    state_next = S_LERP;
                end
            end
            S_LERP: begin
                cmd.op   = OP_LERP;
                cmd.lidx = cnt_reg[2:0];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd4) begin
                    status_next = STAT_VISIBLE;
                    state_next  = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/convex_polygon_segment_clipper_core.sv =====
// Top level of the convex polygon segment clipper: controller, datapath and vertex store.
// Vertex transactions (req_type 0) fill the clip polygon; the one marked last_vertex closes
// it and triggers a convexity pass, or reports a polygon of fewer than three vertices as
// nonconvex. Segment transactions (req_type 1) are clipped edge by edge against a closed
// convex polygon; an edge that yields a parameter also runs the shared divider, which
// produces one quotient bit per cycle. One transaction is processed at a time, and a new
// one is accepted while the previous result still waits in the output register.
module convex_polygon_segment_clipper_core #(
    parameter int MAX_VERTICES = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  cpsc_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output cpsc_pkg::out_t  m_data
);
    import cpsc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    cmd_t          cmd;
    stat_t         stat;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    cpsc_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .req_type    (s_data.req_type),
        .last_vertex (s_data.last_vertex),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .stat        (stat),
        .cmd         (cmd),
        .raddr       (raddr),
        .waddr       (waddr)
    );

    cpsc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .raddr  (raddr),
        .waddr  (waddr),
        .stat   (stat),
        .m_data (m_data)
    );

endmodule

// ===== sim/clip_checker.sv =====
// Checker that watches both channels of the clipper, predicts each result and compares.
`timescale 1ns / 1ps
module clip_checker #(
    parameter int MAX_VERTICES = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  cpsc_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  cpsc_pkg::out_t m_data,
    output int             fail_count,
    output int             pending
);
    import cpsc_pkg::*;

    localparam longint T_ONE = 65536;

    logic [COORD_W-1:0] ring_x [MAX_VERTICES];
    logic [COORD_W-1:0] ring_y [MAX_VERTICES];
    int   ring_len;
    bit   ring_closed;
    bit   ring_convex;
    out_t expected_results [$];

    function automatic bit ring_convex_now(int n);
        bit pos, neg;
        longint ax, ay, bx, by, cx, cy, cr;
        pos = 0;
        neg = 0;
        if (n < 3) return 0;
        for (int i = 0; i < n; i++) begin
            ax = ring_x[i];           ay = ring_y[i];
            bx = ring_x[(i + 1) % n]; by = ring_y[(i + 1) % n];
            cx = ring_x[(i + 2) % n]; cy = ring_y[(i + 2) % n];
            cr = (bx - ax) * (cy - by) - (by - ay) * (cx - bx);
            if (cr > 0) pos = 1;
            else if (cr < 0) neg = 1;
        end
        return !(pos && neg);
    endfunction

    function automatic logic [COORD_W-1:0] point_at(longint p, longint d, longint t);
        longint prod, step;
        prod = d * t;
        step = prod < 0 ? -((-prod) / T_ONE) : prod / T_ONE;
        return COORD_W'(p + step);
    endfunction

    function automatic out_t clip_result(in_t req);
        out_t r;
        longint sx, sy, dx, dy, te, tl, ax, ay, bx, by, mx, my, nx, ny, dp, num, nn, dd, tq;
        bit reject;
        r = '0;
        if (req.req_type == REQ_LOAD) begin
            if (ring_closed) begin
                ring_closed = 0;
                ring_convex = 0;
                ring_len = 0;
            end
            if (ring_len < MAX_VERTICES) begin
                ring_x[ring_len] = req.x0;
                ring_y[ring_len] = req.y0;
                ring_len++;
            end
            if (req.last_vertex) begin
                ring_closed = 1;
                ring_convex = ring_convex_now(ring_len);
                r.status = ring_convex ? STAT_CONVEX : STAT_NONCONVEX;
            end else begin
                r.status = STAT_STORED;
            end
            return r;
        end
        if (!ring_closed || !ring_convex) begin
            r.status = STAT_DISABLED;
            return r;
        end
        sx = req.x0;
        sy = req.y0;
        dx = longint'(req.x1) - sx;
        dy = longint'(req.y1) - sy;
        te = 0;
        tl = T_ONE;
        reject = 0;
        for (int j = 0; j < ring_len; j++) begin
            ax = ring_x[j];                  ay = ring_y[j];
            bx = ring_x[(j + 1) % ring_len]; by = ring_y[(j + 1) % ring_len];
            mx = (ax + bx) / 2;
            my = (ay + by) / 2;
            nx = by - ay;
            ny = ax - bx;
            dp = nx * dx + ny * dy;
            num = -(nx * (sx - mx) + ny * (sy - my));
            if (dp == 0) continue;
            if (dp < 0) begin
                nn = -num;
                dd = -dp;
                if (nn > dd) reject = 1;
                else if (nn > 0) begin
                    tq = (nn * T_ONE) / dd;
                    if (tq > te) te = tq;
                end
            end else begin
                nn = num;
                dd = dp;
                if (nn < 0) reject = 1;
                else if (nn < dd) begin
                    tq = (nn * T_ONE) / dd;
                    if (tq < tl) tl = tq;
                end
            end
        end
        if (reject || te > tl) begin
            r.status = STAT_REJECTED;
            return r;
        end
        r.status = STAT_VISIBLE;
        r.out_x0 = point_at(sx, dx, te);
        r.out_y0 = point_at(sy, dy, te);
        r.out_x1 = point_at(sx, dx, tl);
        r.out_y1 = point_at(sy, dy, tl);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            ring_len = 0;
            ring_closed = 0;
            ring_convex = 0;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", m_data.status, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.out_x0 !== want.out_x0)
                        report_mismatch("out_x0", m_data.out_x0, want.out_x0);
                    if (m_data.out_y0 !== want.out_y0)
                        report_mismatch("out_y0", m_data.out_y0, want.out_y0);
                    if (m_data.out_x1 !== want.out_x1)
                        report_mismatch("out_x1", m_data.out_x1, want.out_x1);
                    if (m_data.out_y1 !== want.out_y1)
                        report_mismatch("out_y1", m_data.out_y1, want.out_y1);
                end
            end
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(), clip_result(s_data));
        end
        pending = expected_results.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: drives vertex and segment transactions into the clipper and gives the verdict.
`timescale 1ns / 1ps
module testbench;
    import cpsc_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_t m_data;
    int   fail_count;
    int   pending;
    bit   calm = 0;
    longint cycles = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    convex_polygon_segment_clipper_core dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    clip_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    int stall_left = 0;
    always @(posedge aclk) begin
        if (calm || !aresetn) begin
            m_ready <= aresetn;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    task automatic send(bit kind, int ax, int ay, int bx, int by, bit last);
        in_t item;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        item.req_type = kind;
        item.x0 = COORD_W'(ax);
        item.y0 = COORD_W'(ay);
        item.x1 = COORD_W'(bx);
        item.y1 = COORD_W'(by);
        item.last_vertex = last;
        s_valid <= 1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic load_polygon(int n, bit regular);
        int cx, cy, rad;
        real ang;
        cx = $urandom_range(1000, 3000);
        cy = $urandom_range(1000, 3000);
        rad = $urandom_range(20, 900);
        for (int i = 0; i < n; i++) begin
            ang = 6.2831853 * i / n;
            if (regular)
                send(0, cx + $rtoi(rad * $cos(ang)), cy + $rtoi(rad * $sin(ang)),
                     $urandom_range(0, 4095), $urandom_range(0, 4095), i == n - 1);
            else
                send(0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095), i == n - 1);
        end
    endtask

    task automatic random_segment();
        if ($urandom_range(0, 9) == 0) begin
            int p, q;
            p = $urandom_range(0, 4095);
            q = $urandom_range(0, 4095);
            send(1, p, q, p, q, $urandom_range(0, 1));
        end else begin
            send(1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 1));
        end
    endtask

    initial begin
        int sent;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send(1, 10, 10, 100, 100, 0);
        send(0, 0, 0, 0, 0, 0);
        send(0, 4095, 4095, 4095, 4095, 1);
        send(1, 0, 0, 4095, 4095, 1);
        send(0, 100, 100, 0, 0, 0);
        send(0, 3000, 100, 0, 0, 0);
        send(0, 3000, 3000, 0, 0, 0);
        send(0, 100, 3000, 0, 0, 1);
        send(1, 0, 0, 4095, 4095, 0);
        send(1, 4095, 0, 0, 4095, 0);
        send(1, 500, 500, 600, 700, 0);
        send(1, 0, 4095, 50, 4000, 0);
        send(1, 2000, 2000, 2000, 2000, 0);
        send(1, 0, 50, 4095, 50, 0);
        send(1, 100, 0, 100, 4095, 0);
        send(0, 0, 0, 0, 0, 0);
        send(0, 4095, 0, 0, 0, 0);
        send(0, 0, 4095, 0, 0, 0);
        send(0, 4095, 4095, 0, 0, 1);
        send(1, 0, 0, 4095, 4095, 0);
        for (int i = 0; i < 18; i++)
            send(0, 200 + 100 * i, 300 + (i % 2) * 500, 0, 0, i == 17);
        send(1, 0, 0, 4095, 4095, 0);
        sent = 39;

        while (sent < 500) begin
            int n, k;
            if (sent == 39 || $urandom_range(0, 9) == 0) begin
                s_valid <= 0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            n = $urandom_range(0, 4) == 0 ? $urandom_range(1, 18) : $urandom_range(3, 8);
            load_polygon(n, $urandom_range(0, 4) != 0);
            k = $urandom_range(3, 12);
            for (int j = 0; j < k; j++)
                random_segment();
            sent += n + k;
            if (sent > 420) calm = 1;
        end

        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
